// ----- sv/wpsa_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and codes of the weighted pixel sample accumulator.
package wpsa_pkg;

   localparam int MAX_TILE_W = 64;
   localparam int MAX_TILE_H = 64;
   localparam int PIX_COUNT  = MAX_TILE_W * MAX_TILE_H;
   localparam int PIX_AW     = (PIX_COUNT > 1) ? $clog2(PIX_COUNT) : 1;
   localparam int X_W        = (MAX_TILE_W > 1) ? $clog2(MAX_TILE_W) : 1;
   localparam int Y_W        = (MAX_TILE_H > 1) ? $clog2(MAX_TILE_H) : 1;

   localparam int COORD_W = 16;
   localparam int ORIG_W  = 16;
   localparam int SIZE_W  = 7;
   localparam int WGT_W   = 16;
   localparam int COLOR_W = 16;
   localparam int RES_W   = 32;
   localparam int WSUM_W  = 48;
   localparam int WT_W    = 40;
   localparam int PSUM_W  = 40;
   localparam int W_W     = 17;
   localparam int PROD_W  = W_W + COLOR_W;
   localparam int CSR_DW  = 16;
   localparam int DIV_CW  = $clog2(WSUM_W);

   typedef enum logic [1:0] {
      CSR_ORIGIN_X = 2'd0,
      CSR_ORIGIN_Y = 2'd1,
      CSR_WIDTH    = 2'd2,
      CSR_HEIGHT   = 2'd3
   } csr_index_type;

   typedef enum logic {
      FUNC_ACCUM = 1'b0,
      FUNC_READ  = 1'b1
   } func_type;

   typedef struct packed {
      logic [2:0][WSUM_W-1:0] wsum;
      logic [WT_W-1:0]        wt;
      logic [2:0][PSUM_W-1:0] psum;
   } pix_row_type;

   typedef struct packed {
      logic              en;
      logic [PIX_AW-1:0] addr;
      pix_row_type       data;
   } mem_wr_type;

   typedef struct packed {
      logic              en;
      logic [PIX_AW-1:0] addr;
   } mem_rd_type;

   typedef struct packed {
      logic              start;
      logic [WSUM_W-1:0] dividend;
      logic [WT_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [WSUM_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_LOCATE    = 7'b0000010,
      ST_MUL       = 7'b0000100,
      ST_WRITE     = 7'b0001000,
      ST_DIV_START = 7'b0010000,
      ST_DIV_WAIT  = 7'b0100000,
      ST_DONE      = 7'b1000000
   } state_type;

endpackage

// ----- sv/wpsa_if.sv -----
`timescale 1ns / 1ps
// Request, response and register-write channel interfaces.
interface wpsa_req_if import wpsa_pkg::*; ;
   logic                      valid;
   logic                      ready;
   logic                      func;
   logic signed [COORD_W-1:0] raster_x;
   logic signed [COORD_W-1:0] raster_y;
   logic [WGT_W-1:0]          sample_weight;
   logic [WGT_W-1:0]          ray_weight;
   logic [COLOR_W-1:0]        red_in;
   logic [COLOR_W-1:0]        green_in;
   logic [COLOR_W-1:0]        blue_in;
   logic                      is_weighted;

   modport source (output valid, func, raster_x, raster_y, sample_weight, ray_weight,
                   red_in, green_in, blue_in, is_weighted, input ready);
   modport sink   (input valid, func, raster_x, raster_y, sample_weight, ray_weight,
                   red_in, green_in, blue_in, is_weighted, output ready);
endinterface

interface wpsa_rsp_if import wpsa_pkg::*; ;
   logic             valid;
   logic             ready;
   logic             accepted;
   logic [RES_W-1:0] red_out;
   logic [RES_W-1:0] green_out;
   logic [RES_W-1:0] blue_out;

   modport source (output valid, accepted, red_out, green_out, blue_out, input ready);
   modport sink   (input valid, accepted, red_out, green_out, blue_out, output ready);
endinterface

interface wpsa_csr_if import wpsa_pkg::*; ;
   logic              valid;
   logic              ready;
   csr_index_type     index;
   logic [CSR_DW-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/wpsa_store.sv -----
`timescale 1ns / 1ps
// Per-pixel accumulation memory with a clearing sweep after reset.
module wpsa_store import wpsa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mem_rd_type  rd,
   input  mem_wr_type  wr,
   output pix_row_type rd_data,
   output logic        ready
);

   pix_row_type       mem [PIX_COUNT];
   pix_row_type       q_ff;
   logic              clearing_ff;
   logic [PIX_AW-1:0] clr_cnt_ff;
   logic              w_en;
   logic [PIX_AW-1:0] w_addr;
   pix_row_type       w_data;

   always_comb begin
      if (clearing_ff) begin
         w_en   = 1'b1;
         w_addr = clr_cnt_ff;
         w_data = '0;
      end else begin
         w_en   = wr.en;
         w_addr = wr.addr;
         w_data = wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clearing_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == PIX_AW'(PIX_COUNT - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (w_en) begin
         mem[w_addr] <= w_data;
      end
      if (rd.en) begin
         q_ff <= mem[rd.addr];
      end
   end

   assign rd_data = q_ff;
   assign ready   = !clearing_ff;

endmodule

// ----- sv/wpsa_div.sv -----
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle.
module wpsa_div import wpsa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [WSUM_W-1:0] quo_ff;
   logic [WT_W-1:0]   rem_ff;
   logic [DIV_CW-1:0] cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [WT_W:0]     trial;
   logic              ge;
   logic [WT_W-1:0]   rem_in;

   always_comb begin
      trial  = {rem_ff, quo_ff[WSUM_W-1]};
      ge     = trial >= (WT_W+1)'(req.divisor);
      rem_in = ge ? WT_W'(trial - (WT_W+1)'(req.divisor)) : trial[WT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == DIV_CW'(WSUM_W - 1));
         if (req.start && !busy_ff) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == DIV_CW'(WSUM_W - 1))) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start && !busy_ff) begin
         quo_ff <= req.dividend;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[WSUM_W-2:0], ge};
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ----- sv/weighted_pixel_sample_accumulator.sv -----
`timescale 1ns / 1ps
// Plain accumulate goes from locate to write to its result; weighted adds a multiply
// step before write (one shared 17x16 multiplier serves the weight product and each
// colour channel); rejected goes from locate to its result. Read starts and waits
// on the restoring divider per channel in turn, one quotient bit a cycle, 48 bits each.
// One item at a time: a beat is taken only in idle, entered as the result registers.
// After reset the store sweeps 4096 rows clear, one a cycle, before any item.
module weighted_pixel_sample_accumulator import wpsa_pkg::*; (
   input logic        clock,
   input logic        reset,
   wpsa_req_if.sink   req_bus,
   wpsa_rsp_if.source rsp_bus,
   wpsa_csr_if.sink   csr_bus
);

   state_type         state_ff, state_in;
   logic [1:0]        chan_ff, chan_in;
   logic [PIX_AW-1:0] addr_ff, addr_in;
   logic [W_W-1:0]    w_ff, w_in;
   logic [PROD_W-1:0] prod_ff [3];
   logic [PROD_W-1:0] prod_in [3];
   logic              acc_ff, acc_in;
   logic [RES_W-1:0]  col_ff [3];
   logic [RES_W-1:0]  col_in [3];
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_acc_ff;
   logic [RES_W-1:0]  out_col_ff [3];

   logic [ORIG_W-1:0] cfg_ox_ff, cfg_oy_ff;
   logic [SIZE_W-1:0] cfg_w_ff, cfg_h_ff;

   func_type           it_func_ff;
   logic [COORD_W-1:0] it_rx_ff, it_ry_ff;
   logic [WGT_W-1:0]   it_sw_ff, it_rw_ff;
   logic [COLOR_W-1:0] it_col_ff [3];
   logic               it_wtd_ff;

   logic              req_fire;
   logic              out_load;
   logic [17:0]       lx, ly;
   logic              in_tile;
   logic [PIX_AW-1:0] loc_addr;
   logic [W_W-1:0]    mul_a;
   logic [COLOR_W-1:0] mul_b;
   logic [PROD_W-1:0] mul_p;
   logic              store_rdy;
   pix_row_type       rd_row;
   pix_row_type       new_row;
   mem_rd_type        store_rd;
   mem_wr_type        store_wr;
   div_req_type       div_req;
   div_rsp_type       div_rsp;
   logic [WSUM_W-1:0] quot;

   function automatic logic [WSUM_W-1:0] sat_wsum(input logic [WSUM_W-1:0] a,
                                                  input logic [PROD_W-1:0] b);
      logic [WSUM_W:0] s;
      s = {1'b0, a} + (WSUM_W+1)'(b);
      return s[WSUM_W] ? '1 : s[WSUM_W-1:0];
   endfunction

   function automatic logic [WT_W-1:0] sat_wt(input logic [WT_W-1:0] a,
                                              input logic [W_W-1:0] b);
      logic [WT_W:0] s;
      s = {1'b0, a} + (WT_W+1)'(b);
      return s[WT_W] ? '1 : s[WT_W-1:0];
   endfunction

   function automatic logic [PSUM_W-1:0] sat_psum(input logic [PSUM_W-1:0] a,
                                                  input logic [COLOR_W-1:0] b);
      logic [PSUM_W:0] s;
      s = {1'b0, a} + (PSUM_W+1)'(b);
      return s[PSUM_W] ? '1 : s[PSUM_W-1:0];
   endfunction

   function automatic logic [RES_W-1:0] sat_res(input logic [PSUM_W-1:0] p,
                                                input logic [WSUM_W-1:0] q);
      logic [WSUM_W:0] s;
      s = (WSUM_W+1)'(p) + {1'b0, q};
      return (|s[WSUM_W:RES_W]) ? '1 : s[RES_W-1:0];
   endfunction

   wpsa_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd      (store_rd),
      .wr      (store_wr),
      .rd_data (rd_row),
      .ready   (store_rdy)
   );

   wpsa_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_bus.ready = (state_ff == ST_IDLE) && store_rdy;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ox_ff <= '0;
         cfg_oy_ff <= '0;
         cfg_w_ff  <= SIZE_W'(64);
         cfg_h_ff  <= SIZE_W'(64);
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_ORIGIN_X: cfg_ox_ff <= csr_bus.data;
            CSR_ORIGIN_Y: cfg_oy_ff <= csr_bus.data;
            CSR_WIDTH:    cfg_w_ff  <= csr_bus.data[SIZE_W-1:0];
            CSR_HEIGHT:   cfg_h_ff  <= csr_bus.data[SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         it_func_ff   <= func_type'(req_bus.func);
         it_rx_ff     <= req_bus.raster_x;
         it_ry_ff     <= req_bus.raster_y;
         it_sw_ff     <= req_bus.sample_weight;
         it_rw_ff     <= req_bus.ray_weight;
         it_col_ff[0] <= req_bus.red_in;
         it_col_ff[1] <= req_bus.green_in;
         it_col_ff[2] <= req_bus.blue_in;
         it_wtd_ff    <= req_bus.is_weighted;
      end
   end

   always_comb begin
      lx = {{2{it_rx_ff[COORD_W-1]}}, it_rx_ff} - {2'b00, cfg_ox_ff};
      ly = {{2{it_ry_ff[COORD_W-1]}}, it_ry_ff} - {2'b00, cfg_oy_ff};
      in_tile = !lx[17] && (lx[16:0] < 17'(cfg_w_ff)) && (lx[16:0] < 17'(MAX_TILE_W))
             && !ly[17] && (ly[16:0] < 17'(cfg_h_ff)) && (ly[16:0] < 17'(MAX_TILE_H));
      loc_addr = PIX_AW'(ly[Y_W-1:0]) * PIX_AW'(MAX_TILE_W) + PIX_AW'(lx[X_W-1:0]);
   end

   always_comb begin
      if (state_ff == ST_LOCATE) begin
         mul_a = {1'b0, it_sw_ff};
         mul_b = it_rw_ff;
      end else begin
         mul_a = w_ff;
         mul_b = it_col_ff[chan_ff];
      end
      mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_comb begin
      new_row = rd_row;
      for (int c = 0; c < 3; c++) begin
         if (it_wtd_ff) begin
            new_row.wsum[c] = sat_wsum(rd_row.wsum[c], prod_ff[c]);
         end else begin
            new_row.psum[c] = sat_psum(rd_row.psum[c], it_col_ff[c]);
         end
      end
      if (it_wtd_ff) begin
         new_row.wt = sat_wt(rd_row.wt, w_ff);
      end
   end

   assign quot = (rd_row.wt != '0) ? div_rsp.quotient : '0;

   always_comb begin
      store_rd.en      = (state_ff == ST_LOCATE) && in_tile;
      store_rd.addr    = loc_addr;
      store_wr.en      = (state_ff == ST_WRITE);
      store_wr.addr    = addr_ff;
      store_wr.data    = new_row;
      div_req.start    = (state_ff == ST_DIV_START);
      div_req.dividend = rd_row.wsum[chan_ff];
      div_req.divisor  = rd_row.wt;
   end

   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      addr_in      = addr_ff;
      w_in         = w_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      col_in       = col_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_LOCATE;
            end
         end
         ST_LOCATE: begin
            acc_in  = in_tile;
            addr_in = loc_addr;
            w_in    = mul_p[WGT_W+WGT_W-1:WGT_W-1];
            chan_in = '0;
            for (int c = 0; c < 3; c++) begin
               col_in[c] = '0;
            end
            if (!in_tile) begin
               state_in = ST_DONE;
            end else if (it_func_ff == FUNC_READ) begin
               state_in = ST_DIV_START;
            end else if (it_wtd_ff) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_MUL: begin
            prod_in[chan_ff] = mul_p;
            if (chan_ff == 2'd2) begin
               state_in = ST_WRITE;
            end else begin
               chan_in = chan_ff + 1'b1;
            end
         end
         ST_WRITE: begin
            state_in = ST_DONE;
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               col_in[chan_ff] = sat_res(rd_row.psum[chan_ff], quot);
               if (chan_ff == 2'd2) begin
                  state_in = ST_DONE;
               end else begin
                  chan_in  = chan_ff + 1'b1;
                  state_in = ST_DIV_START;
               end
            end
         end
         ST_DONE: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chan_ff <= chan_in;
      addr_ff <= addr_in;
      w_ff    <= w_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      col_ff  <= col_in;
      if (out_load) begin
         out_acc_ff <= acc_ff;
         out_col_ff <= col_ff;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.accepted  = out_acc_ff;
   assign rsp_bus.red_out   = out_col_ff[0];
   assign rsp_bus.green_out = out_col_ff[1];
   assign rsp_bus.blue_out  = out_col_ff[2];

   a_write_only_in_write: assert property (@(posedge clock) disable iff (reset)
      store_wr.en |-> (state_ff == ST_WRITE))
      else $error("store written outside the write step");

   a_accept_to_locate: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_LOCATE))
      else $error("accepted beat did not start a pixel lookup");

   a_div_start_free: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_bus.ready) |=> (state_ff == ST_DONE))
      else $error("pending result overwritten");

endmodule

// ----- dv/wpsa_pixel_check.sv -----
`timescale 1ns / 1ps
// Pixel store predictor and response checker for the sample accumulator bench.
module wpsa_pixel_check import wpsa_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   wpsa_req_if    req_mon,
   wpsa_rsp_if    rsp_mon,
   wpsa_csr_if    csr_mon,
   output int     fail_count,
   output int     in_flight
);

   localparam bit [63:0] WSUM_MAX = (64'd1 << WSUM_W) - 64'd1;
   localparam bit [63:0] WT_MAX   = (64'd1 << WT_W) - 64'd1;
   localparam bit [63:0] PSUM_MAX = (64'd1 << PSUM_W) - 64'd1;
   localparam bit [63:0] RES_MAX  = (64'd1 << RES_W) - 64'd1;

   typedef struct packed {
      logic             accepted;
      logic [RES_W-1:0] red;
      logic [RES_W-1:0] green;
      logic [RES_W-1:0] blue;
   } resolved_pixel_type;

   bit [ORIG_W-1:0] org_x;
   bit [ORIG_W-1:0] org_y;
   bit [SIZE_W-1:0] tile_w;
   bit [SIZE_W-1:0] tile_h;

   bit [WSUM_W-1:0] wsum_acc [PIX_COUNT][3];
   bit [WT_W-1:0]   wt_acc   [PIX_COUNT];
   bit [PSUM_W-1:0] psum_acc [PIX_COUNT][3];

   resolved_pixel_type expected_pixels [$];
   int                 mismatches;

   assign fail_count = mismatches;

   function automatic bit [63:0] clip_sum(input bit [63:0] a, input bit [63:0] b,
                                          input bit [63:0] limit);
      bit [63:0] s;
      s = a + b;
      return (s > limit) ? limit : s;
   endfunction

   function automatic resolved_pixel_type apply_sample();
      resolved_pixel_type res;
      longint          lx, ly, w_lim, h_lim;
      int              pix;
      bit [63:0]       wgt, sum;
      bit [63:0]       hue [3];
      bit [63:0]       chan [3];
      res   = '0;
      lx    = longint'(req_mon.raster_x) - longint'(org_x);
      ly    = longint'(req_mon.raster_y) - longint'(org_y);
      w_lim = (tile_w > MAX_TILE_W) ? longint'(MAX_TILE_W) : longint'(tile_w);
      h_lim = (tile_h > MAX_TILE_H) ? longint'(MAX_TILE_H) : longint'(tile_h);
      if (lx < 0 || ly < 0 || lx >= w_lim || ly >= h_lim) return res;
      pix          = int'(ly) * MAX_TILE_W + int'(lx);
      res.accepted = 1'b1;
      hue[0]       = 64'(req_mon.red_in);
      hue[1]       = 64'(req_mon.green_in);
      hue[2]       = 64'(req_mon.blue_in);
      if (req_mon.func == FUNC_ACCUM) begin
         if (req_mon.is_weighted) begin
            wgt = (64'(req_mon.sample_weight) * 64'(req_mon.ray_weight)) >> 15;
            for (int c = 0; c < 3; c++)
               wsum_acc[pix][c] = WSUM_W'(clip_sum(wsum_acc[pix][c], wgt * hue[c], WSUM_MAX));
            wt_acc[pix] = WT_W'(clip_sum(wt_acc[pix], wgt, WT_MAX));
         end else begin
            for (int c = 0; c < 3; c++)
               psum_acc[pix][c] = PSUM_W'(clip_sum(psum_acc[pix][c], hue[c], PSUM_MAX));
         end
      end else begin
         for (int c = 0; c < 3; c++) begin
            sum = 64'(psum_acc[pix][c]);
            if (wt_acc[pix] != 0) sum = sum + 64'(wsum_acc[pix][c]) / 64'(wt_acc[pix]);
            chan[c] = (sum > RES_MAX) ? RES_MAX : sum;
         end
         res.red   = chan[0][RES_W-1:0];
         res.green = chan[1][RES_W-1:0];
         res.blue  = chan[2][RES_W-1:0];
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch_beats
      resolved_pixel_type seen;
      resolved_pixel_type want;
      if (reset) begin
         org_x  = '0;
         org_y  = '0;
         tile_w = SIZE_W'(MAX_TILE_W);
         tile_h = SIZE_W'(MAX_TILE_H);
         for (int p = 0; p < PIX_COUNT; p++) begin
            wt_acc[p] = '0;
            for (int c = 0; c < 3; c++) begin
               wsum_acc[p][c] = '0;
               psum_acc[p][c] = '0;
            end
         end
         expected_pixels.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_ORIGIN_X: org_x = csr_mon.data[ORIG_W-1:0];
               CSR_ORIGIN_Y: org_y = csr_mon.data[ORIG_W-1:0];
               CSR_WIDTH:    tile_w = csr_mon.data[SIZE_W-1:0];
               CSR_HEIGHT:   tile_h = csr_mon.data[SIZE_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) expected_pixels.push_back(apply_sample());
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.accepted = rsp_mon.accepted;
            seen.red      = rsp_mon.red_out;
            seen.green    = rsp_mon.green_out;
            seen.blue     = rsp_mon.blue_out;
            if (expected_pixels.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: result beat with no sample pending: acc=%0d r=%h g=%h b=%h",
                           $realtime, seen.accepted, seen.red, seen.green, seen.blue);
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               if (seen !== want) begin
                  if (mismatches < 10)
                     $display("%0t: mismatch: expected %0d %h %h %h, got %0d %h %h %h",
                              $realtime, want.accepted, want.red, want.green, want.blue,
                              seen.accepted, seen.red, seen.green, seen.blue);
                  mismatches++;
               end
            end
         end
      end
      in_flight <= expected_pixels.size();
   end

endmodule

// ----- dv/weighted_pixel_sample_accumulator_tb.sv -----
`timescale 1ns / 1ps
// Stimulus, flow control and verdict for the weighted pixel sample accumulator.
module weighted_pixel_sample_accumulator_tb;
   import wpsa_pkg::*;

   localparam int STALL_LIMIT   = 20000;
   localparam int RANDOM_PHASES = 5;
   localparam int LONG_HOLD     = 300;

   logic clock;
   logic reset;

   wpsa_req_if req_bus();
   wpsa_rsp_if rsp_bus();
   wpsa_csr_if csr_bus();

   int fail_count;
   int in_flight;
   int idle_cycles;
   int req_beats;
   int rsp_beats;
   int cur_ox, cur_oy, cur_w, cur_h;
   bit send_quiet;
   bit recv_quiet;

   weighted_pixel_sample_accumulator i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   wpsa_pixel_check i_pixel_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_mon    (csr_bus),
      .fail_count (fail_count),
      .in_flight  (in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_sample(input func_type fn, input int rx, input int ry,
                              input logic [15:0] sw, input logic [15:0] rw,
                              input logic [15:0] red, input logic [15:0] green,
                              input logic [15:0] blue, input logic wtd);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.func          <= fn;
      req_bus.raster_x      <= rx[15:0];
      req_bus.raster_y      <= ry[15:0];
      req_bus.sample_weight <= sw;
      req_bus.ray_weight    <= rw;
      req_bus.red_in        <= red;
      req_bus.green_in      <= green;
      req_bus.blue_in       <= blue;
      req_bus.is_weighted   <= wtd;
      req_bus.valid         <= 1'b1;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      req_beats++;
      if (req_beats % 64 == 0) send_quiet = ($urandom_range(0, 3) == 0);
      @(negedge clock);
   endtask

   task automatic send_random();
      int          pick, rx, ry;
      func_type    fn;
      logic [15:0] wt [2];
      pick = $urandom_range(0, 99);
      rx   = cur_ox + $urandom_range(0, (cur_w > 0) ? cur_w - 1 : 0);
      ry   = cur_oy + $urandom_range(0, (cur_h > 0) ? cur_h - 1 : 0);
      if (cur_w == 0 || cur_h == 0 || pick < 12) begin
         rx = $urandom;
         ry = $urandom;
      end else if (pick < 20) begin
         case ($urandom_range(0, 3))
            0: rx = cur_ox - 1;
            1: rx = cur_ox + cur_w;
            2: ry = cur_oy - 1;
            default: ry = cur_oy + cur_h;
         endcase
      end else if (pick < 60) begin
         rx = cur_ox + ($urandom_range(0, 1) ? 0 : cur_w - 1);
         ry = cur_oy + ($urandom_range(0, 1) ? 0 : cur_h - 1);
      end
      fn = ($urandom_range(0, 99) < 35) ? FUNC_READ : FUNC_ACCUM;
      for (int k = 0; k < 2; k++) begin
         case ($urandom_range(0, 7))
            0: wt[k] = 16'h0000;
            1: wt[k] = 16'hFFFF;
            2: wt[k] = 16'h8000;
            default: wt[k] = 16'($urandom);
         endcase
      end
      send_sample(fn, rx, ry, wt[0], wt[1], 16'($urandom), 16'($urandom), 16'($urandom),
                  1'($urandom_range(0, 1)));
   endtask

   task automatic write_reg(input csr_index_type idx, input int value);
      csr_bus.index <= idx;
      csr_bus.data  <= value[CSR_DW-1:0];
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      @(negedge clock);
   endtask

   task automatic run_phase(input int ox, input int oy, input int w, input int h,
                            input int count);
      while (in_flight != 0) @(negedge clock);
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
      csr_bus.valid <= 1'b0;
      cur_ox = ox;
      cur_oy = oy;
      cur_w  = (w > MAX_TILE_W) ? MAX_TILE_W : w;
      cur_h  = (h > MAX_TILE_H) ? MAX_TILE_H : h;
      repeat (count) send_random();
      req_bus.valid <= 1'b0;
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         int gap;
         if (rsp_beats == 400 || rsp_beats == 1100) gap = LONG_HOLD;
         else gap = recv_quiet ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         rsp_beats++;
         if (rsp_beats % 64 == 0) recv_quiet = ($urandom_range(0, 3) == 0);
         @(negedge clock);
      end
   end

   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.func          = FUNC_ACCUM;
      req_bus.raster_x      = '0;
      req_bus.raster_y      = '0;
      req_bus.sample_weight = '0;
      req_bus.ray_weight    = '0;
      req_bus.red_in        = '0;
      req_bus.green_in      = '0;
      req_bus.blue_in       = '0;
      req_bus.is_weighted   = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = CSR_ORIGIN_X;
      csr_bus.data          = '0;
      cur_ox = 0;
      cur_oy = 0;
      cur_w  = MAX_TILE_W;
      cur_h  = MAX_TILE_H;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_sample(FUNC_READ,  0, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_sample(FUNC_ACCUM, 0, 0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      send_sample(FUNC_ACCUM, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000, 1'b1);
      send_sample(FUNC_ACCUM, 1, 0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_sample(FUNC_READ,  1, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_sample(FUNC_READ,  0, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_sample(FUNC_ACCUM, 63, 63, 16'h8000, 16'h8000, 16'h1234, 16'h5678, 16'h9ABC, 1'b1);
      send_sample(FUNC_ACCUM, 63, 63, 16'h0001, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h7FFF, 1'b1);
      send_sample(FUNC_ACCUM, 63, 63, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0002, 16'h0003, 1'b0);
      send_sample(FUNC_READ,  63, 63, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 1'b1);
      send_sample(FUNC_ACCUM, 64, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_sample(FUNC_ACCUM, 0, 64, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      send_sample(FUNC_ACCUM, -1, 5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_sample(FUNC_ACCUM, 5, -32768, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      send_sample(FUNC_ACCUM, 32767, 32767, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  1'b1);
      send_sample(FUNC_READ,  64, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_sample(FUNC_READ,  -32768, -1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  1'b0);
      send_sample(FUNC_ACCUM, 0, 0, 16'h0001, 16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_sample(FUNC_READ,  0, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
      send_sample(FUNC_READ,  63, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      req_bus.valid <= 1'b0;

      run_phase(0, 0, 64, 64, 250);
      run_phase(1000, 2000, 1, 1, 120);
      run_phase(32767, 32767, 1, 1, 100);
      run_phase($urandom_range(0, 5000), $urandom_range(0, 5000), 100, 127, 200);
      run_phase(0, 0, 0, 10, 60);
      run_phase(0, 0, 10, 0, 30);
      run_phase(65535, 0, 64, 64, 40);
      repeat (RANDOM_PHASES)
         run_phase($urandom_range(0, 32000), $urandom_range(0, 32000), $urandom_range(1, 64),
                   $urandom_range(1, 64), 140);

      while (in_flight != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (fail_count == 0 && in_flight == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- weighted_pixel_sample_accumulator.f -----
sv/wpsa_pkg.sv
sv/wpsa_if.sv
sv/wpsa_store.sv
sv/wpsa_div.sv
sv/weighted_pixel_sample_accumulator.sv
dv/wpsa_pixel_check.sv
dv/weighted_pixel_sample_accumulator_tb.sv
